>>> hw/rtl/mm_pkg.sv
package mm_pkg;

    localparam int ROWS_A = 8;
    localparam int INNER  = 8;
    localparam int COLS_B = 8;
    localparam int DIM    = 8;
    localparam int IDX_W  = 3;

    localparam logic [1:0] ACT_WRITE_A  = 2'd0;
    localparam logic [1:0] ACT_WRITE_B  = 2'd1;
    localparam logic [1:0] ACT_MULTIPLY = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_WAIT
    } state_t;

    typedef struct packed {
        logic [1:0]         action;
        logic [IDX_W-1:0]   row_index;
        logic [IDX_W-1:0]   col_index;
        logic signed [15:0] element_value;
    } cmd_item_t;

    typedef struct packed {
        logic signed [35:0] product_value;
        logic [IDX_W-1:0]   out_row;
        logic [IDX_W-1:0]   out_col;
        logic               last;
    } res_item_t;

    // partial sum traveling down the cell chain
    typedef struct packed {
        logic               valid;
        logic [IDX_W-1:0]   row;
        logic [IDX_W-1:0]   col;
        logic               last;
        logic signed [35:0] acc;
    } link_t;

    // element write into one cell
    typedef struct packed {
        logic               a_en;
        logic               b_en;
        logic [IDX_W-1:0]   a_idx;
        logic [IDX_W-1:0]   b_idx;
        logic signed [15:0] data;
    } wr_t;

endpackage

>>> hw/rtl/matrix_multiply.sv
// channel  valid      stall      payload  direction
// cmd      cmd_valid  cmd_stall  cmd      in   (element write or multiply)
// res      res_valid  res_stall  res      out  (one element of C)
//
// Element writes are taken one per cycle while no multiply is running.
// During a multiply the sequencer issues one C element per cycle, unless
// res_stall holds it, into a chain of INNER cells, each adding one product
// over two register stages.
// res_stall freezes the whole chain while res_valid is high; cmd_stall is high until the last item leaves.
// Reset clears control only; the A and B stores hold garbage until written.
module matrix_multiply (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    output logic              cmd_stall,
    input  mm_pkg::cmd_item_t cmd,
    output logic              res_valid,
    input  logic              res_stall,
    output mm_pkg::res_item_t res
);
    import mm_pkg::*;

    logic      advance;
    logic      cmd_take;
    logic      run_done;
    logic      busy;
    link_t     link [INNER+1];
    wr_t       wr_bus [INNER];

    logic      res_valid_reg;
    res_item_t res_reg;

    assign advance   = !res_valid_reg || !res_stall;
    assign cmd_stall = busy;
    assign cmd_take  = cmd_valid && !busy;
    assign run_done  = res_valid_reg && !res_stall && res_reg.last;

    mm_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_take),
        .cmd       (cmd),
        .advance   (advance),
        .run_done  (run_done),
        .busy      (busy),
        .issue     (link[0])
    );

    // A[r][k] goes to cell k at entry r, B[k][c] to cell k at entry c
    always_comb begin
        for (int k = 0; k < INNER; k++) begin
            wr_bus[k].a_en  = cmd_take && cmd.action == ACT_WRITE_A
                              && cmd.col_index == IDX_W'(k)
                              && 32'(cmd.row_index) < ROWS_A;
            wr_bus[k].b_en  = cmd_take && cmd.action == ACT_WRITE_B
                              && cmd.row_index == IDX_W'(k)
                              && 32'(cmd.col_index) < COLS_B;
            wr_bus[k].a_idx = cmd.row_index;
            wr_bus[k].b_idx = cmd.col_index;
            wr_bus[k].data  = cmd.element_value;
        end
    end

    for (genvar k = 0; k < INNER; k++) begin : g_cell
        mm_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .advance  (advance),
            .wr       (wr_bus[k]),
            .link_in  (link[k]),
            .link_out (link[k+1])
        );
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            res_valid_reg <= 1'b0;
        end
        else if (advance) begin
            res_valid_reg <= link[INNER].valid;
        end
    end

    always_ff @(posedge clk) begin
        if (advance) begin
            res_reg.product_value <= link[INNER].acc;
            res_reg.out_row       <= link[INNER].row;
            res_reg.out_col       <= link[INNER].col;
            res_reg.last          <= link[INNER].last;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

`ifndef SYNTH
    // nothing is left in flight once the block takes commands again
    a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd_stall |-> !res_valid)
        else $error("result pending while idle");

    // taking the final item ends the run
    a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_stall && res.last |=> !cmd_stall)
        else $error("block still busy after final item");

    // the chain streams with no bubbles inside a run
    a_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_stall && !res.last |=> res_valid)
        else $error("gap in result stream");
`endif

endmodule

>>> hw/rtl/mm_cell.sv
module mm_cell (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          advance,
    input  mm_pkg::wr_t   wr,
    input  mm_pkg::link_t link_in,
    output mm_pkg::link_t link_out
);
    import mm_pkg::*;

    // cell k holds column k of A and row k of B
    logic signed [15:0] a_col_reg [DIM];
    logic signed [15:0] b_row_reg [DIM];

    logic                valid1_reg;
    logic [IDX_W-1:0]    row1_reg;
    logic [IDX_W-1:0]    col1_reg;
    logic                last1_reg;
    logic signed [31:0]  prod_reg;
    logic signed [35:0]  acc1_reg;

    logic                valid2_reg;
    logic [IDX_W-1:0]    row2_reg;
    logic [IDX_W-1:0]    col2_reg;
    logic                last2_reg;
    logic signed [35:0]  sum_reg;

    logic signed [31:0]  prod_next;
    logic signed [35:0]  sum_next;

    always_ff @(posedge clk) begin
        if (wr.a_en) begin
            a_col_reg[wr.a_idx] <= wr.data;
        end
        if (wr.b_en) begin
            b_row_reg[wr.b_idx] <= wr.data;
        end
    end

    assign prod_next = a_col_reg[link_in.row] * b_row_reg[link_in.col];
    assign sum_next  = acc1_reg + {{4{prod_reg[31]}}, prod_reg};

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            valid1_reg <= 1'b0;
            valid2_reg <= 1'b0;
        end
        else if (advance) begin
            valid1_reg <= link_in.valid;
            valid2_reg <= valid1_reg;
        end
    end

    always_ff @(posedge clk) begin
        if (advance) begin
            row1_reg  <= link_in.row;
            col1_reg  <= link_in.col;
            last1_reg <= link_in.last;
            prod_reg  <= prod_next;
            acc1_reg  <= link_in.acc;
            row2_reg  <= row1_reg;
            col2_reg  <= col1_reg;
            last2_reg <= last1_reg;
            sum_reg   <= sum_next;
        end
    end

    assign link_out.valid = valid2_reg;
    assign link_out.row   = row2_reg;
    assign link_out.col   = col2_reg;
    assign link_out.last  = last2_reg;
    assign link_out.acc   = sum_reg;

endmodule

>>> hw/rtl/mm_seq.sv
module mm_seq (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    input  mm_pkg::cmd_item_t cmd,
    input  logic              advance,
    input  logic              run_done,
    output logic              busy,
    output mm_pkg::link_t     issue
);
    import mm_pkg::*;

    state_t           state_reg;
    state_t           state_next;
    logic [IDX_W-1:0] r_cnt_reg;
    logic [IDX_W-1:0] r_cnt_next;
    logic [IDX_W-1:0] c_cnt_reg;
    logic [IDX_W-1:0] c_cnt_next;
    logic             final_elem;

    assign final_elem = (r_cnt_reg == IDX_W'(ROWS_A - 1)) && (c_cnt_reg == IDX_W'(COLS_B - 1));

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (cmd_valid && cmd.action == ACT_MULTIPLY) begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN: begin
                if (advance && final_elem) begin
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT: begin
                if (run_done) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        r_cnt_next = r_cnt_reg;
        c_cnt_next = c_cnt_reg;
        if (state_reg == ST_RUN && advance) begin
            if (c_cnt_reg == IDX_W'(COLS_B - 1)) begin
                c_cnt_next = '0;
                r_cnt_next = final_elem ? '0 : r_cnt_reg + 1'b1;
            end
            else begin
                c_cnt_next = c_cnt_reg + 1'b1;
            end
        end
    end

    always_comb begin
        busy        = 1'b1;
        issue.valid = 1'b0;
        issue.row   = r_cnt_reg;
        issue.col   = c_cnt_reg;
        issue.last  = final_elem;
        issue.acc   = '0;
        case (state_reg)
            ST_IDLE: busy        = 1'b0;
            ST_RUN:  issue.valid = 1'b1;
            ST_WAIT: busy        = 1'b1;
            default: busy        = 1'b1;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg <= ST_IDLE;
            r_cnt_reg <= '0;
            c_cnt_reg <= '0;
        end
        else begin
            state_reg <= state_next;
            r_cnt_reg <= r_cnt_next;
            c_cnt_reg <= c_cnt_next;
        end
    end

endmodule
